/* design/sidac_pkg.sv */
// ----------------------------------------------------------------------------
// sidac_pkg
// Shared constants and control types for the signed integer to decimal
// ASCII unit.
// ----------------------------------------------------------------------------
package sidac_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CHAR_WIDTH = 7;
  localparam int OUT_DATA_WIDTH = 8;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'd45;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
    logic emit_sign;
  } sidac_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic top_zero;
    logic left_one;
    logic neg;
  } sidac_status_t;

endpackage

/* design/sidac_datapath.sv */
// ----------------------------------------------------------------------------
// sidac_datapath
// Magnitude register, shift-add-3 bcd converter, step counter and
// digit shifter that feeds characters out most significant first.
// ----------------------------------------------------------------------------
module sidac_datapath #(
  parameter int VALUE_WIDTH = sidac_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [VALUE_WIDTH-1:0]              in_value,
  input  sidac_pkg::sidac_cmd_t               cmd,
  output sidac_pkg::sidac_status_t            status,
  output logic [sidac_pkg::CHAR_WIDTH-1:0]    char_code
);

  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(VALUE_WIDTH + 1);
  localparam int DW   = $clog2(NDIG + 1);

  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BW-1:0]          bcd_r, bcd_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [DW-1:0]          left_r, left_nxt;
  logic [BW-1:0]          adj;
  logic [3:0]             top_digit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    left_nxt = left_r;
    if (cmd.load) begin
      neg_nxt  = in_value[VALUE_WIDTH-1];
      mag_nxt  = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
      bcd_nxt  = '0;
      cnt_nxt  = CW'(VALUE_WIDTH);
      left_nxt = DW'(NDIG);
    end else if (cmd.step) begin
      bcd_nxt = {adj[BW-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end else if (cmd.shift) begin
      bcd_nxt  = {bcd_r[BW-5:0], 4'b0000};
      left_nxt = left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      left_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      left_r <= left_nxt;
    end
  end

  assign top_digit = bcd_r[BW-1 -: 4];

  assign status.cnt_last = (cnt_r == CW'(1));
  assign status.top_zero = (top_digit == 4'd0);
  assign status.left_one = (left_r == DW'(1));
  assign status.neg      = neg_r;

  assign char_code = cmd.emit_sign ? sidac_pkg::ASCII_MINUS
                                   : sidac_pkg::ASCII_ZERO + {3'b000, top_digit};

endmodule

/* design/sidac_ctrl.sv */
// ----------------------------------------------------------------------------
// sidac_ctrl
// Sequencer: load, bcd conversion steps, leading zero skip, sign and
// digit emission with output handshake.
// ----------------------------------------------------------------------------
module sidac_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic                      out_tlast,
  input  sidac_pkg::sidac_status_t  status,
  output sidac_pkg::sidac_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    out_tlast  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (status.cnt_last) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (status.top_zero && !status.left_one) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = status.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_tvalid    = 1'b1;
        cmd.emit_sign = 1'b1;
        if (out_tready) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        out_tlast  = status.left_one;
        if (out_tready) begin
          if (status.left_one) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.shift = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/signed_int_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts one signed integer into its decimal ascii text, sign first,
// digits most significant first, no leading zeros, last character tlast.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser  tlast
// in       in   value [VALUE_WIDTH-1:0]        -      -
// out      out  char_code [6:0], zero [7]      -      is_last
//
// one request in idle, then one shift-add-3 step per value bit in the bcd
// converter, one shift per leading zero digit, then one character
// per cycle while out_tready is high, sign first when negative;
// out_tready stalls hold the sequence
// synchronous active-low reset returns the sequencer to idle
// in_tready is high only in idle; a stalled character holds its value
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = sidac_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       in_tdata,   // value
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [sidac_pkg::OUT_DATA_WIDTH-1:0]   out_tdata,  // char_code, zero pad
  output logic                                   out_tlast
);

  sidac_pkg::sidac_cmd_t              cmd;
  sidac_pkg::sidac_status_t           status;
  logic [sidac_pkg::CHAR_WIDTH-1:0]   char_code;

  sidac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .status     (status),
    .cmd        (cmd)
  );

  sidac_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_tdata[VALUE_WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status),
    .char_code (char_code)
  );

  assign out_tdata = {1'b0, char_code};

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request accepted while characters pending");

  a_quiet_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("character before conversion finished");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not idle after last character");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == 8'd45 || (out_tdata >= 8'd48 && out_tdata <= 8'd57)))
    else $error("character out of set");

endmodule
